/* hdl/bmts_pkg.sv */
`default_nettype none

package bmts_pkg;

    localparam int VOCAB_SIZE_DEF = 256;
    localparam int COUNT_BITS_DEF = 16;

    localparam int WORD_BITS   = 8;
    localparam int DRAW_BITS   = 32;
    localparam int STATUS_BITS = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

endpackage

`default_nettype wire

/* hdl/bmts_ram.sv */
`default_nettype none

module bmts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/bmts_mod.sv */
`default_nettype none

module bmts_mod #(
    parameter int COUNT_BITS = bmts_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [bmts_pkg::DRAW_BITS-1:0] dividend,
    input  wire logic [COUNT_BITS-1:0]          divisor,
    output logic                                done,
    output logic      [COUNT_BITS-1:0]          remainder
);

    localparam int CNT_BITS = $clog2(bmts_pkg::DRAW_BITS + 1);

    logic [CNT_BITS-1:0]            cnt_reg;
    logic [CNT_BITS-1:0]            cnt_next;
    logic                           done_reg;
    logic                           done_next;
    logic [bmts_pkg::DRAW_BITS-1:0] dvd_reg;
    logic [bmts_pkg::DRAW_BITS-1:0] dvd_next;
    logic [COUNT_BITS-1:0]          dvs_reg;
    logic [COUNT_BITS-1:0]          dvs_next;
    logic [COUNT_BITS-1:0]          rem_reg;
    logic [COUNT_BITS-1:0]          rem_next;
    logic [COUNT_BITS:0]            trial;
    logic [COUNT_BITS:0]            diff;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[bmts_pkg::DRAW_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CNT_BITS'(bmts_pkg::DRAW_BITS);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
            dvd_next  = {dvd_reg[bmts_pkg::DRAW_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[COUNT_BITS-1:0];
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hdl/bigram_markov_table_sampler.sv */
// Bigram transition table with weighted successor sampling.
// Input channel (in_valid/in_ready) takes one word: operation, word_id and
// random_draw. Output channel (out_valid/out_ready) returns one word per input
// word: next_word and status, in input order.
// Learn (operation 0) of an in-vocabulary word bumps the count from the held
// previous word, if any, to word_id and that row's total unless that total is
// saturated, then holds word_id as the previous word. Sample (operation 1)
// reduces random_draw modulo the row total of word_id and walks the row's
// counts in successor order until the running sum exceeds it. A learn with a
// previous word passes the check state on its way to the output register; a
// sample passes the row total read, the bit-serial modulo unit (one quotient
// bit a cycle) and the walk, one count a cycle from the transition memory.
// in_ready is high only while the sequencer is idle. A finished result sits in
// the output register; the next word may be accepted meanwhile, and its result
// waits until the receiver has taken the previous one.
// After reset the block clears both memories, one transition entry a cycle,
// over all 2^(2*ceil(log2(VOCAB_SIZE))) entries (65536 at 256 words); in_ready
// stays low until that pass is done. The previous word is forgotten at reset.
`default_nettype none

module bigram_markov_table_sampler #(
    parameter int VOCAB_SIZE = bmts_pkg::VOCAB_SIZE_DEF,
    parameter int COUNT_BITS = bmts_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             operation,
    input  wire logic [bmts_pkg::WORD_BITS-1:0]   word_id,
    input  wire logic [bmts_pkg::DRAW_BITS-1:0]   random_draw,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [bmts_pkg::WORD_BITS-1:0]   next_word,
    output logic      [bmts_pkg::STATUS_BITS-1:0] status
);

    localparam int IDX_BITS = $clog2(VOCAB_SIZE);
    localparam int ROWS     = 1 << IDX_BITS;
    localparam int TC_AW    = 2 * IDX_BITS;
    localparam int TC_DEPTH = 1 << TC_AW;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_LCHK  = 8'b0000_0100,
        S_SRD   = 8'b0000_1000,
        S_SMOD  = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_RESP  = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [TC_AW-1:0]                clr_cnt_reg;
    logic [TC_AW-1:0]                clr_cnt_next;
    logic                            prev_valid_reg;
    logic                            prev_valid_next;
    logic [IDX_BITS-1:0]             last_word_reg;
    logic [IDX_BITS-1:0]             last_word_next;
    logic [IDX_BITS-1:0]             row_reg;
    logic [IDX_BITS-1:0]             row_next;
    logic [IDX_BITS-1:0]             col_reg;
    logic [IDX_BITS-1:0]             col_next;
    logic [bmts_pkg::DRAW_BITS-1:0]  draw_reg;
    logic [bmts_pkg::DRAW_BITS-1:0]  draw_next;
    logic [COUNT_BITS-1:0]           total_reg;
    logic [COUNT_BITS-1:0]           total_next;
    logic [COUNT_BITS-1:0]           target_reg;
    logic [COUNT_BITS-1:0]           target_next;
    logic [COUNT_BITS:0]             running_reg;
    logic [COUNT_BITS:0]             running_next;
    logic [IDX_BITS-1:0]             rd_idx_reg;
    logic [IDX_BITS-1:0]             rd_idx_next;
    logic                            dv_reg;
    logic                            dv_next;
    logic [IDX_BITS-1:0]             didx_reg;
    logic [IDX_BITS-1:0]             didx_next;
    logic [bmts_pkg::WORD_BITS-1:0]  res_word_reg;
    logic [bmts_pkg::WORD_BITS-1:0]  res_word_next;
    bmts_pkg::status_t               res_status_reg;
    bmts_pkg::status_t               res_status_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [bmts_pkg::WORD_BITS-1:0]  next_word_reg;
    logic [bmts_pkg::WORD_BITS-1:0]  next_word_next;
    bmts_pkg::status_t               status_reg;
    bmts_pkg::status_t               status_next;

    logic                            in_fire;
    logic                            in_vocab;
    logic [IDX_BITS-1:0]             widx;
    logic [COUNT_BITS:0]             walk_sum;

    logic                            rt_we;
    logic [IDX_BITS-1:0]             rt_waddr;
    logic [COUNT_BITS-1:0]           rt_wdata;
    logic [IDX_BITS-1:0]             rt_raddr;
    logic [COUNT_BITS-1:0]           rt_rdata;
    logic                            tc_we;
    logic [TC_AW-1:0]                tc_waddr;
    logic [COUNT_BITS-1:0]           tc_wdata;
    logic [TC_AW-1:0]                tc_raddr;
    logic [COUNT_BITS-1:0]           tc_rdata;

    logic                            mod_start;
    logic                            mod_done;
    logic [COUNT_BITS-1:0]           mod_rem;

    bmts_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ROWS)
    ) u_row_totals (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (rt_raddr),
        .rdata (rt_rdata)
    );

    bmts_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TC_DEPTH)
    ) u_trans_counts (
        .clk   (clk),
        .we    (tc_we),
        .waddr (tc_waddr),
        .wdata (tc_wdata),
        .raddr (tc_raddr),
        .rdata (tc_rdata)
    );

    bmts_mod #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (draw_reg),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_vocab = ({24'd0, word_id} < 32'(VOCAB_SIZE));
    assign widx     = IDX_BITS'(word_id);
    assign walk_sum = running_reg + {1'b0, tc_rdata};

    // Read addresses: in idle the reads for the arriving word are issued at once.
    always_comb
    begin
        if (state_reg == S_WALK)
        begin
            rt_raddr = row_reg;
            tc_raddr = {row_reg, rd_idx_reg};
        end
        else
        begin
            rt_raddr = operation ? widx : last_word_reg;
            tc_raddr = {last_word_reg, widx};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        prev_valid_next = prev_valid_reg;
        last_word_next  = last_word_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        draw_next       = draw_reg;
        total_next      = total_reg;
        target_next     = target_reg;
        running_next    = running_reg;
        rd_idx_next     = rd_idx_reg;
        dv_next         = dv_reg;
        didx_next       = didx_reg;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        next_word_next  = next_word_reg;
        status_next     = status_reg;
        rt_we           = 1'b0;
        rt_waddr        = row_reg;
        rt_wdata        = rt_rdata + 1'b1;
        tc_we           = 1'b0;
        tc_waddr        = {row_reg, col_reg};
        tc_wdata        = tc_rdata + 1'b1;
        mod_start       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                rt_we        = 1'b1;
                rt_waddr     = clr_cnt_reg[IDX_BITS-1:0];
                rt_wdata     = '0;
                tc_we        = 1'b1;
                tc_waddr     = clr_cnt_reg;
                tc_wdata     = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_word_next   = '0;
                    res_status_next = bmts_pkg::ST_OK;
                    draw_next       = random_draw;
                    col_next        = widx;
                    row_next        = operation ? widx : last_word_reg;
                    priority if (!in_vocab)
                    begin
                        res_status_next = operation ? bmts_pkg::ST_EMPTY : bmts_pkg::ST_OK;
                        state_next      = S_RESP;
                    end
                    else if (operation)
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        last_word_next  = widx;
                        prev_valid_next = 1'b1;
                        state_next      = prev_valid_reg ? S_LCHK : S_RESP;
                    end
                end
            end
            S_LCHK:
            begin
                if (rt_rdata == '1)
                begin
                    res_status_next = bmts_pkg::ST_SATURATED;
                end
                else
                begin
                    rt_we = 1'b1;
                    tc_we = 1'b1;
                end
                state_next = S_RESP;
            end
            S_SRD:
            begin
                total_next = rt_rdata;
                if (rt_rdata == '0)
                begin
                    res_status_next = bmts_pkg::ST_EMPTY;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                mod_start  = 1'b1;
                state_next = S_SMOD;
            end
            S_SMOD:
            begin
                if (mod_done)
                begin
                    target_next  = mod_rem;
                    running_next = '0;
                    rd_idx_next  = '0;
                    dv_next      = 1'b0;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                // Reads are issued one a cycle; the count for didx_reg arrives now.
                rd_idx_next = rd_idx_reg + 1'b1;
                dv_next     = 1'b1;
                didx_next   = rd_idx_reg;
                if (dv_reg)
                begin
                    running_next = walk_sum;
                    priority if (walk_sum > {1'b0, target_reg})
                    begin
                        running_next    = running_reg;
                        res_word_next   = bmts_pkg::WORD_BITS'(didx_reg);
                        res_status_next = bmts_pkg::ST_OK;
                        state_next      = S_RESP;
                    end
                    else if (didx_reg == IDX_BITS'(VOCAB_SIZE - 1))
                    begin
                        res_status_next = bmts_pkg::ST_EMPTY;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    next_word_next = res_word_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            prev_valid_reg <= 1'b0;
            last_word_reg  <= '0;
            out_valid_reg  <= 1'b0;
            dv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            prev_valid_reg <= prev_valid_next;
            last_word_reg  <= last_word_next;
            out_valid_reg  <= out_valid_next;
            dv_reg         <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        draw_reg       <= draw_next;
        total_reg      <= total_next;
        target_reg     <= target_next;
        running_reg    <= running_next;
        rd_idx_reg     <= rd_idx_next;
        didx_reg       <= didx_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        next_word_reg  <= next_word_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign next_word = next_word_reg;
    assign status    = status_reg;

`ifndef SYNTH
    a_fail_word_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != bmts_pkg::ST_OK) |-> next_word_reg == '0)
        else $error("non-ok result carries a nonzero successor");

    a_walk_below_target : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> running_reg <= {1'b0, target_reg})
        else $error("walk running sum passed the target without stopping");

    a_mod_range : assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> mod_rem < total_reg)
        else $error("reduced draw not below the row total");
`endif

endmodule

`default_nettype wire

/* test/bigram_markov_table_sampler_tb.sv */
`timescale 1ns / 1ps

module bigram_markov_table_sampler_tb;

    localparam logic OP_LEARN  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam int RANDOM_WORDS = 1890;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic       op;
        logic [7:0] word;
        logic [31:0] draw;
        int         reps;
        bit         typed;
        logic [7:0] exp_word;
        bmts_pkg::status_t exp_status;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] next_word;
        bmts_pkg::status_t status;
    } successor_t;

    localparam int N_DIRECTED = 25;

    // Row 255 gets a run of back-to-back repeated learns onto itself.
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_SAMPLE, 8'd0,   32'h0000_0000, 1,  1'b1, 8'd0,   bmts_pkg::ST_EMPTY},
        '{OP_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1,  1'b1, 8'd0,   bmts_pkg::ST_EMPTY},
        '{OP_LEARN,  8'd0,   32'h5A5A_5A5A, 1,  1'b1, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd0,   32'h0000_0005, 1,  1'b1, 8'd0,   bmts_pkg::ST_EMPTY},
        '{OP_LEARN,  8'd255, 32'hA5A5_A5A5, 1,  1'b1, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd0,   32'hFFFF_FFFF, 1,  1'b1, 8'd255, bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd0,   32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd1,   32'hFFFF_FFFF, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd0,   32'h1234_5678, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd1,   32'h0000_0001, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd0,   32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd0,   32'h0000_0002, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd0,   32'hFFFF_FFFF, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd1,   32'd12345,     1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd128, 32'h8000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd128, 32'h7FFF_FFFF, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd128, 32'h8000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd255, 32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd255, 32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd255, 32'h0000_0000, 40, 1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd0,   32'hFFFF_FFFF, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd255, 32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd255, 32'hFFFF_FFFF, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_SAMPLE, 8'd255, 32'd65534,     1,  1'b0, 8'd0,   bmts_pkg::ST_OK},
        '{OP_LEARN,  8'd255, 32'h0000_0000, 1,  1'b0, 8'd0,   bmts_pkg::ST_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [7:0]  word_id = 8'd0;
    logic [31:0] random_draw = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  next_word;
    logic [1:0]  status;

    logic [15:0] trans_count [256][256];
    logic [15:0] row_total [256];
    logic [7:0]  last_word;
    bit          have_prev;

    successor_t  pending_results [$];
    int          errors = 0;
    int          results_seen = 0;
    int          hold_at = -1;
    bit          no_idle = 1'b0;

    bigram_markov_table_sampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .word_id     (word_id),
        .random_draw (random_draw),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_word   (next_word),
        .status      (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_successor(input logic op, input logic [7:0] w,
                                              input logic [31:0] d,
                                              output logic [7:0] succ,
                                              output bmts_pkg::status_t st);
        logic [31:0] target;
        logic [31:0] running;
        bit          found;
        succ = 8'd0;
        st = bmts_pkg::ST_OK;
        if (op == OP_LEARN)
        begin
            if (have_prev)
            begin
                if (row_total[last_word] == COUNT_MAX)
                    st = bmts_pkg::ST_SATURATED;
                else
                begin
                    row_total[last_word] = row_total[last_word] + 16'd1;
                    trans_count[last_word][w] = trans_count[last_word][w] + 16'd1;
                end
            end
            last_word = w;
            have_prev = 1'b1;
        end
        else if (row_total[w] == 16'd0)
            st = bmts_pkg::ST_EMPTY;
        else
        begin
            target = d % {16'd0, row_total[w]};
            running = 32'd0;
            found = 1'b0;
            st = bmts_pkg::ST_EMPTY;
            for (int j = 0; j < 256; j++)
            begin
                if (!found)
                begin
                    running = running + {16'd0, trans_count[w][j]};
                    if (running > target)
                    begin
                        succ = 8'(j);
                        st = bmts_pkg::ST_OK;
                        found = 1'b1;
                    end
                end
            end
        end
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic offer_word(input logic op, input logic [7:0] w, input logic [31:0] d,
                              input int gap, input bit typed,
                              input logic [7:0] typed_word,
                              input bmts_pkg::status_t typed_status);
        successor_t exp_r;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        word_id <= w;
        random_draw <= d;
        do @(posedge clk); while (!in_ready);
        predict_successor(op, w, d, exp_r.next_word, exp_r.status);
        if (typed)
        begin
            exp_r.next_word = typed_word;
            exp_r.status = typed_status;
        end
        pending_results.push_back(exp_r);
    endtask

    initial
    begin
        for (int a = 0; a < 256; a++)
        begin
            row_total[a] = 16'd0;
            for (int b = 0; b < 256; b++)
                trans_count[a][b] = 16'd0;
        end
        last_word = 8'd0;
        have_prev = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
            begin
                no_idle = DIRECTED[r].reps > 1;
                offer_word(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].draw,
                           no_idle ? 0 : int'($urandom_range(0, 4)), DIRECTED[r].typed,
                           DIRECTED[r].exp_word, DIRECTED[r].exp_status);
            end
        end

        hold_at = results_seen + 150;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            logic        op;
            logic [7:0]  w;
            logic [31:0] d;
            int          pick;
            no_idle = (i % 400) < 50;
            op = ($urandom_range(0, 99) < 40) ? OP_SAMPLE : OP_LEARN;
            // Mostly a small vocabulary so that rows fill up and samples land on them.
            pick = $urandom_range(0, 99);
            if (pick < 60)
                w = 8'($urandom_range(0, 15));
            else if (pick < 64)
                w = 8'd255;
            else if (pick < 67)
                w = 8'd0;
            else if (pick < 70)
                w = 8'd128;
            else
                w = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                d = 32'h0000_0000;
            else if (pick < 30)
                d = 32'hFFFF_FFFF;
            else if (pick < 50)
                d = $urandom_range(0, 63);
            else
                d = $urandom;
            offer_word(op, w, d, no_idle ? 0 : int'($urandom_range(0, 4)),
                       1'b0, 8'd0, bmts_pkg::ST_OK);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("bigram_markov_table_sampler_tb passed");
        else
            $display("bigram_markov_table_sampler_tb failed");
        $finish;
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            int         idle;
            successor_t exp_r;
            idle = no_idle ? 0 : int'($urandom_range(0, 4));
            // One long hold-off lets the block fill up and stall its input.
            if (results_seen == hold_at)
                idle = HOLD_CYCLES;
            if (idle > 0)
            begin
                out_ready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $error("unexpected word: next_word %0d status %0d", next_word, status);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (next_word !== exp_r.next_word)
                begin
                    $error("next_word expected %0d actual %0d", exp_r.next_word, next_word);
                    errors++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    errors++;
                end
            end
            results_seen++;
        end
    end

    initial
    begin
        #40_000_000;
        $display("bigram_markov_table_sampler_tb failed");
        $finish;
    end

endmodule

/* bigram_markov_table_sampler.f */
hdl/bmts_pkg.sv
hdl/bmts_ram.sv
hdl/bmts_mod.sv
hdl/bigram_markov_table_sampler.sv
test/bigram_markov_table_sampler_tb.sv
